### src/smss_pkg.sv
// Shared constants and types for the sorted matrix staircase search block.
`default_nettype none

package smss_pkg;

    // Default sizing.
    localparam int DEF_MAX_ROWS   = 16;
    localparam int DEF_MAX_COLS   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    // Fixed field widths.
    localparam int FIELD_W  = 32;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [CNT_W-1:0] CNT_RESET = 5'd16;

    // Operation codes.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Register index, taken from paddr[2].
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // Command from the top level to the walker.
    typedef struct packed {
        logic             start;
        logic             ack;
        logic [CNT_W-1:0] rows;
        logic [CNT_W-1:0] cols;
    } t_walk_cmd;

    // Status from the walker.
    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } t_walk_sts;

endpackage

`default_nettype wire

### src/sorted_matrix_staircase_search.sv
// Top level: staircase search over a row- and column-sorted matrix.
// Load word: written at its accept edge, no result; the next word can be taken next cycle.
// Search word: first store read at the accept edge, then one store read and compare per walk step;
//   the walker holds its answer until the output register is free, then o_out_valid rises.
// Input is stalled from the cycle after a search is taken until its result enters the output reg.
// Synchronous active-low reset: walker idle, output empty, row_count = col_count = 16.
// The matrix store is not cleared by reset; its contents are undefined until loaded.
`default_nettype none

module sorted_matrix_staircase_search
    import smss_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // input channel
    input  wire logic                      i_in_valid,
    output      logic                      o_in_stall,
    input  wire logic                      i_operation,
    input  wire logic [IDX_W-1:0]          i_load_row,
    input  wire logic [IDX_W-1:0]          i_load_col,
    input  wire logic signed [FIELD_W-1:0] i_load_value,
    input  wire logic signed [FIELD_W-1:0] i_search_value,
    // result channel
    output      logic                      o_out_valid,
    input  wire logic                      i_out_stall,
    output      logic                      o_found,
    // configuration port
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_AW-1:0]         paddr,
    input  wire logic [APB_DW-1:0]         pwdata,
    output      logic [APB_DW-1:0]         prdata,
    output      logic                      pready
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // ---------------- configuration registers ----------------
    logic [CNT_W-1:0] r_row_count;
    logic [CNT_W-1:0] r_col_count;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CNT_RESET;
            r_col_count <= CNT_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_ROW_COUNT: r_row_count <= pwdata[CNT_W-1:0];
                REG_COL_COUNT: r_col_count <= pwdata[CNT_W-1:0];
                default:       r_row_count <= r_row_count;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ROW_COUNT: prdata = {{(APB_DW-CNT_W){1'b0}}, r_row_count};
            REG_COL_COUNT: prdata = {{(APB_DW-CNT_W){1'b0}}, r_col_count};
            default:       prdata = '0;
        endcase
    end

    // counts above the store size act as the store size
    logic [CNT_W-1:0] w_rows;
    logic [CNT_W-1:0] w_cols;

    assign w_rows = (int'(r_row_count) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : r_row_count;
    assign w_cols = (int'(r_col_count) > MAX_COLS) ? CNT_W'(MAX_COLS) : r_col_count;

    // ---------------- input accept ----------------
    t_walk_sts w_sts;
    t_walk_cmd w_cmd;
    logic      w_in_acc;
    logic      w_out_free;

    assign o_in_stall = w_sts.busy;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // load path: row-major address, words outside the store dropped
    logic                  w_wr_en;
    logic [ADDR_W-1:0]     w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;

    assign w_wr_en   = w_in_acc && (i_operation == OP_LOAD)
                       && (int'(i_load_row) < MAX_ROWS) && (int'(i_load_col) < MAX_COLS);
    assign w_wr_addr = ADDR_W'(int'(i_load_row) * MAX_COLS + int'(i_load_col));
    assign w_wr_data = DATA_WIDTH'(i_load_value);   // sign-extend or wrap

    // search target at the store's width
    logic signed [DATA_WIDTH-1:0] w_target;
    assign w_target = DATA_WIDTH'(i_search_value);

    assign w_cmd.start = w_in_acc && (i_operation == OP_SEARCH);
    assign w_cmd.ack   = w_sts.done && w_out_free;
    assign w_cmd.rows  = w_rows;
    assign w_cmd.cols  = w_cols;

    // ---------------- store and walker ----------------
    logic                         w_rd_en;
    logic [ADDR_W-1:0]            w_rd_addr;
    logic signed [DATA_WIDTH-1:0] w_rd_data;

    smss_mem #(
        .DEPTH      (DEPTH),
        .ADDR_W     (ADDR_W),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    smss_walker #(
        .MAX_COLS   (MAX_COLS),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_target  (w_target),
        .i_rd_data (w_rd_data),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .o_sts     (w_sts)
    );

    // ---------------- output register ----------------
    // Walker holds its answer until this register can take it.
    logic r_out_valid;
    logic r_found;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_sts.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_found <= w_sts.found;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;

endmodule

`default_nettype wire

### src/smss_mem.sv
// Matrix element store: one write port, one read port with registered data.
`default_nettype none

module smss_mem #(
    parameter int DEPTH      = 256,
    parameter int ADDR_W     = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_wr_en,
    input  wire logic [ADDR_W-1:0]     i_wr_addr,
    input  wire logic [DATA_WIDTH-1:0] i_wr_data,
    input  wire logic                  i_rd_en,
    input  wire logic [ADDR_W-1:0]     i_rd_addr,
    output      logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### src/smss_walker.sv
// Staircase walk sequencer: one store read and one compare per step.
`default_nettype none

module smss_walker
    import smss_pkg::*;
#(
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int ADDR_W     = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_walk_cmd                    i_cmd,
    input  wire logic signed [DATA_WIDTH-1:0] i_target,
    input  wire logic signed [DATA_WIDTH-1:0] i_rd_data,
    output      logic                         o_rd_en,
    output      logic [ADDR_W-1:0]            o_rd_addr,
    output      t_walk_sts                    o_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_row, n_row;
    logic [CNT_W-1:0]        r_col, n_col;     // column index plus one
    logic [CNT_W-1:0]        r_rows, n_rows;
    logic [ADDR_W-1:0]       r_addr, n_addr;
    logic signed [DATA_WIDTH-1:0] r_target, n_target;
    logic                    r_found, n_found;

    logic w_eq;
    logic w_lt;

    assign w_eq = (i_rd_data == r_target);
    assign w_lt = (r_target < i_rd_data);

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_rows    = r_rows;
        n_addr    = r_addr;
        n_target  = r_target;
        n_found   = r_found;
        o_rd_en   = 1'b0;
        o_rd_addr = r_addr;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_rows   = i_cmd.rows;
                    n_target = i_target;
                    n_found  = 1'b0;
                    if (i_cmd.rows == '0 || i_cmd.cols == '0) begin
                        n_state = S_DONE;
                    end else begin
                        // top-right corner of the used area
                        n_row     = '0;
                        n_col     = i_cmd.cols;
                        n_addr    = ADDR_W'(i_cmd.cols - 5'd1);
                        o_rd_en   = 1'b1;
                        o_rd_addr = n_addr;
                        n_state   = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (w_eq) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else if (w_lt) begin
                    // step left
                    if (r_col == 5'd1) begin
                        n_state = S_DONE;
                    end else begin
                        n_col     = r_col - 5'd1;
                        n_addr    = r_addr - ADDR_W'(1);
                        o_rd_en   = 1'b1;
                        o_rd_addr = n_addr;
                    end
                end else begin
                    // step down
                    if (r_row + 5'd1 == r_rows) begin
                        n_state = S_DONE;
                    end else begin
                        n_row     = r_row + 5'd1;
                        n_addr    = r_addr + ADDR_W'(MAX_COLS);
                        o_rd_en   = 1'b1;
                        o_rd_addr = n_addr;
                    end
                end
            end
            S_DONE: begin
                if (i_cmd.ack) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
        r_row    <= n_row;
        r_col    <= n_col;
        r_rows   <= n_rows;
        r_addr   <= n_addr;
        r_target <= n_target;
    end

    assign o_sts.busy  = (r_state != S_IDLE);
    assign o_sts.done  = (r_state == S_DONE);
    assign o_sts.found = r_found;

endmodule

`default_nettype wire

### src/smss_checker.sv
// Port-level checks for the staircase search block, bound to the top level.
`default_nettype none

module smss_checker
    import smss_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_stall,
    input wire logic i_operation,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire logic o_found
);

    logic w_acc;
    assign w_acc = i_in_valid && !o_in_stall;

    // a load never holds up the next word
    a_load_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_operation == OP_LOAD) |=> !o_in_stall)
        else $error("stall after load word");

    // a search always occupies the walker next cycle
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_operation == OP_SEARCH) |=> o_in_stall)
        else $error("no stall after search word");

    // stall only starts right after a search was taken
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(w_acc && i_operation == OP_SEARCH))
        else $error("stall without a search");

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_found)))
        else $error("result dropped or changed while stalled");

endmodule

bind sorted_matrix_staircase_search smss_checker u_smss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_operation (i_operation),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_found     (o_found)
);

`default_nettype wire

### verif/sorted_matrix_staircase_search_tb.sv
// Testbench for sorted_matrix_staircase_search: self-checking staircase walk with random traffic.
`timescale 1ns / 100ps

module sorted_matrix_staircase_search_tb;
    import smss_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 6;
    // Long enough for the worst search to reach the output register.
    localparam int SETTLE_CYCLES  = 40;
    // Cycles in a row with no word moving on either channel and no register access.
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic signed [FIELD_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [FIELD_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // Everything driven into the block starts at a known value.
    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_stall;
    logic                      i_operation    = OP_LOAD;
    logic [IDX_W-1:0]          i_load_row     = '0;
    logic [IDX_W-1:0]          i_load_col     = '0;
    logic signed [FIELD_W-1:0] i_load_value   = '0;
    logic signed [FIELD_W-1:0] i_search_value = '0;
    logic                      o_out_valid;
    logic                      i_out_stall    = 1'b0;
    logic                      o_found;
    logic                      psel           = 1'b0;
    logic                      penable        = 1'b0;
    logic                      pwrite         = 1'b0;
    logic [APB_AW-1:0]         paddr          = '0;
    logic [APB_DW-1:0]         pwdata         = '0;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    // Percent of cycles in which the sender holds back / the receiver stalls.
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int n_err        = 0;
    int quiet_cycles = 0;

    // Shadow of the block: element store and the two count registers.
    logic signed [FIELD_W-1:0] cells [16][16];
    logic [CNT_W-1:0]          row_cfg = CNT_RESET;
    logic [CNT_W-1:0]          col_cfg = CNT_RESET;
    // Found flags of accepted searches, oldest first.
    bit                        pending_found [$];

    sorted_matrix_staircase_search i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_load_row     (i_load_row),
        .i_load_col     (i_load_col),
        .i_load_value   (i_load_value),
        .i_search_value (i_search_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Staircase walk from the top-right corner of the used area.
    // Counts above 16 act as 16; a zero count leaves nothing to walk.
    function automatic bit staircase_found(input logic signed [FIELD_W-1:0] target);
        int rows;
        int cols;
        int r;
        int c;
        bit hit;
        rows = (row_cfg > 16) ? 16 : int'(row_cfg);
        cols = (col_cfg > 16) ? 16 : int'(col_cfg);
        r    = 0;
        c    = cols;                // column plus one; zero means walked off the left
        hit  = 1'b0;
        while (r < rows && c > 0 && !hit) begin
            if (cells[r][c-1] == target)
                hit = 1'b1;
            else if (target < cells[r][c-1])
                c--;
            else
                r++;
        end
        return hit;
    endfunction

    // Present one word and hold it until taken. Gaps drop valid for whole cycles
    // only; back-to-back words keep valid high, so it is never lowered and raised
    // in one step. The shadow is updated at the accepting edge.
    task automatic send_word(input logic op, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col,
                             input logic signed [FIELD_W-1:0] ld,
                             input logic signed [FIELD_W-1:0] srch);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_load_row     <= row;
        i_load_col     <= col;
        i_load_value   <= ld;
        i_search_value <= srch;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (op == OP_LOAD)
            cells[row][col] = ld;
        else
            pending_found.push_back(staircase_found(srch));
    endtask

    // Unused fields of each word carry random bits.
    task automatic load_cell(input int r, input int c, input logic signed [FIELD_W-1:0] v);
        send_word(OP_LOAD, IDX_W'(r), IDX_W'(c), v, $urandom);
    endtask

    task automatic search_for(input logic signed [FIELD_W-1:0] v);
        send_word(OP_SEARCH, IDX_W'($urandom), IDX_W'($urandom), $urandom, v);
    endtask

    // Let every outstanding result come back, then give a trailing search time to end.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_found.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write a count register (setup + access), then read it back the same way.
    task automatic write_count_reg(input logic reg_sel, input logic [CNT_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (reg_sel == REG_ROW_COUNT)
            row_cfg = value;
        else
            col_cfg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata[CNT_W-1:0] !== value) begin
            $error("%s: expected %0d, actual %0d",
                   (reg_sel == REG_ROW_COUNT) ? "row_count" : "col_count",
                   value, prdata[CNT_W-1:0]);
            n_err++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Registers change only with the block idle.
    task automatic set_area(input int rows, input int cols);
        settle();
        write_count_reg(REG_ROW_COUNT, CNT_W'(rows));
        write_count_reg(REG_COL_COUNT, CNT_W'(cols));
    endtask

    // Load a rows x cols block with values ascending along rows and columns.
    // Styles: hugging the low end with duplicates, mid range, wide steps that
    // saturate at the top, and hugging the high end.
    task automatic fill_sorted(input int rows, input int cols);
        longint      grid [16][16];
        longint      start;
        longint      base;
        int unsigned step_max;
        case ($urandom_range(3))
            0: begin
                start    = -64'sd2147483648;
                step_max = 3;
            end
            1: begin
                start    = longint'(int'($urandom));
                step_max = 1000;
            end
            2: begin
                start    = -64'sd2147483648 + longint'($urandom_range(1000));
                step_max = 1 << 28;
            end
            default: begin
                start    = 64'sd2147483647 - 40;
                step_max = 2;
            end
        endcase
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if (r == 0 && c == 0)
                    base = start;
                else if (r == 0)
                    base = grid[r][c-1];
                else if (c == 0)
                    base = grid[r-1][c];
                else
                    base = (grid[r-1][c] > grid[r][c-1]) ? grid[r-1][c] : grid[r][c-1];
                grid[r][c] = base + longint'($urandom_range(step_max));
                if (grid[r][c] > 64'sd2147483647)
                    grid[r][c] = 64'sd2147483647;
                load_cell(r, c, 32'(grid[r][c]));
            end
        end
    endtask

    // Mostly values that sit in the used area, some near misses, some noise.
    function automatic logic signed [FIELD_W-1:0] pick_target(input int rows, input int cols);
        int                        k;
        logic signed [FIELD_W-1:0] v;
        k = $urandom_range(99);
        v = cells[$urandom_range(rows - 1)][$urandom_range(cols - 1)];
        if (k < 65)
            return v;
        else if (k < 80)
            return v + 1;
        else if (k < 90)
            return v - 1;
        else if (k < 96)
            return $urandom;
        else if (k < 98)
            return VAL_MIN;
        else
            return VAL_MAX;
    endfunction

    // 2 x 3 area with both value extremes, hits in every cell, misses between them.
    // Loads at the far rows/columns of the store lie outside the area and are never read.
    task automatic test_small_area();
        set_area(2, 3);
        load_cell(0, 0, VAL_MIN);
        load_cell(0, 1, -5);
        load_cell(0, 2, 0);
        load_cell(1, 0, -4);
        load_cell(1, 1, 7);
        load_cell(1, 2, VAL_MAX);
        load_cell(15, 15, $urandom);
        load_cell(0, 15, VAL_MAX);
        load_cell(15, 0, VAL_MIN);
        search_for(VAL_MIN);
        search_for(VAL_MAX);
        search_for(0);
        search_for(7);
        search_for(-4);
        search_for(-5);
        search_for(-3);
        search_for(8);
        search_for(VAL_MAX - 1);
        search_for(VAL_MIN + 1);
    endtask

    // A zero count in either dimension: nothing is read, never found.
    task automatic test_empty_area();
        set_area(0, 0);
        search_for(0);
        set_area(0, 16);
        search_for(VAL_MIN);
        set_area(31, 0);
        search_for($urandom);
    endtask

    // Whole store filled; counts past 16 must behave as 16.
    // After this every element has been written at least once.
    task automatic test_count_clamp();
        set_area(16, 16);
        fill_sorted(16, 16);
        repeat (8) search_for(pick_target(16, 16));
        set_area(17, 31);
        repeat (8) search_for(pick_target(16, 16));
        set_area(31, 17);
        repeat (8) search_for(pick_target(16, 16));
    endtask

    // Fresh sorted area per round; the first rounds take the size extremes.
    task automatic test_sorted_rounds(input int n_rounds, input int n_searches);
        int rows;
        int cols;
        for (int i = 0; i < n_rounds; i++) begin
            case (i)
                0: begin
                    rows = 1;
                    cols = 1;
                end
                1: begin
                    rows = 16;
                    cols = 16;
                end
                2: begin
                    rows = 1;
                    cols = 16;
                end
                3: begin
                    rows = 16;
                    cols = 1;
                end
                default: begin
                    rows = $urandom_range(1, 6);
                    cols = $urandom_range(1, 6);
                end
            endcase
            set_area(rows, cols);
            fill_sorted(rows, cols);
            repeat (n_searches) search_for(pick_target(rows, cols));
        end
    endtask

    // Unsorted contents and any count. Safe because the whole store is written.
    task automatic test_unsorted(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0)
                set_area($urandom_range(0, 31), $urandom_range(0, 31));
            if ($urandom_range(1))
                load_cell($urandom_range(15), $urandom_range(15),
                          ($urandom_range(3) == 0) ?
                          cells[$urandom_range(15)][$urandom_range(15)] : $urandom);
            else
                search_for(($urandom_range(2) == 0) ?
                           $urandom : cells[$urandom_range(15)][$urandom_range(15)]);
        end
    endtask

    // Result side: check each word taken, then pick the next cycle's stall.
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_found.size() == 0) begin
                $error("found: expected no word, actual %0b", o_found);
                n_err++;
            end else begin
                want = pending_found.pop_front();
                if (o_found !== want) begin
                    $error("found: expected %0b, actual %0b", want, o_found);
                    n_err++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    // Watchdog: any word moved or register access restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[sorted_matrix_staircase_search] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender gappy, receiver mostly stalled
        snd_idle_pct = 33;
        rcv_idle_pct = 72;
        test_small_area();
        test_empty_area();
        test_count_clamp();

        // sender mostly idle, receiver lightly stalled
        snd_idle_pct = 72;
        rcv_idle_pct = 33;
        test_sorted_rounds(10, 24);

        // full rate both ways
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_sorted_rounds(10, 24);
        test_unsorted(160);

        settle();
        if (n_err == 0 && pending_found.size() == 0)
            $display("[sorted_matrix_staircase_search] OK");
        else
            $display("[sorted_matrix_staircase_search] ERROR");
        $finish;
    end

endmodule
